/* hdl/afs_pkg.sv */
// Package for the audio format fallback selector: types, rate table and masks.
`timescale 1ns / 1ps
package afs_pkg;

    localparam int RATE_LEN      = 10;
    localparam int NUM_RATES_DEF = 10;
    localparam int MASK_W        = 40;
    localparam int IDX_W         = 6;
    localparam int RIDX_W        = 4;

    // Bit 4*r + 2*w + s: s = stereo, w = 16-bit samples.
    localparam logic [MASK_W-1:0] STEREO_BITS = 40'hAA_AAAA_AAAA;
    localparam logic [MASK_W-1:0] WIDE_BITS   = 40'hCC_CCCC_CCCC;

    localparam logic [16:0] RATE_TABLE [RATE_LEN] = '{
        17'd8000,  17'd11025, 17'd16000, 17'd22050, 17'd24000,
        17'd32000, 17'd44100, 17'd48000, 17'd88200, 17'd96000
    };

    localparam logic [15:0] CHANS_MONO   = 16'd1;
    localparam logic [15:0] CHANS_STEREO = 16'd2;
    localparam logic [15:0] BITS_NARROW  = 16'd8;
    localparam logic [15:0] BITS_WIDE    = 16'd16;

    localparam logic [1:0] OUT_MONO   = 2'd1;
    localparam logic [1:0] OUT_STEREO = 2'd2;
    localparam logic [4:0] OUT_NARROW = 5'd8;
    localparam logic [4:0] OUT_WIDE   = 5'd16;

    typedef enum logic {
        SCAN_LOW,
        SCAN_HIGH
    } t_scan;

    typedef struct packed {
        logic [15:0]        desired_channels;
        logic [15:0]        desired_bits;
        logic signed [31:0] desired_rate;
    } t_req;

    typedef struct packed {
        logic        found;
        logic [5:0]  chosen_index;
        logic [1:0]  chosen_channels;
        logic [4:0]  chosen_bits;
        logic [16:0] chosen_rate;
    } t_res;

    // Ones in the low n bits of the support mask.
    function automatic logic [MASK_W-1:0] low_ones(input int n);
        logic [MASK_W-1:0] m;
        m = '0;
        for (int k = 0; k < MASK_W; k++) begin
            m[k] = (k < n);
        end
        return m;
    endfunction

endpackage

/* hdl/afs_if.sv */
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface afs_req_if;
    logic          valid;
    logic          ready;
    afs_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface afs_res_if;
    logic          valid;
    logic          ready;
    afs_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/audio_format_fallback_select_core.sv */
// Audio format fallback selector: four-stage pipeline from request to chosen format.
// A request passes through the stage 1, 2, 3 and 4 registers in order; stage 4 drives the result.
// Throughput: one request per cycle; each stage holds under backpressure and
//   frees as soon as the stage behind it moves.
// Reset: synchronous, active low; clears stage valid bits and the support mask.
// The pipeline is empty after reset; no clearing pass is needed.
`timescale 1ns / 1ps
module audio_format_fallback_select_core #(
    parameter int NUM_RATES = afs_pkg::NUM_RATES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [afs_pkg::MASK_W-1:0]   i_cfg_data,
    afs_req_if.sink                      i_req,
    afs_res_if.source                    o_res
);

    // Rates beyond the table are never usable.
    localparam int RATE_CNT = (NUM_RATES < afs_pkg::RATE_LEN) ? NUM_RATES : afs_pkg::RATE_LEN;
    localparam logic [afs_pkg::MASK_W-1:0] USABLE = afs_pkg::low_ones(4 * RATE_CNT);

    // Support mask register
    logic [afs_pkg::MASK_W-1:0] r_supported_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supported_mask <= '0;
        end else if (i_cfg_we) begin
            r_supported_mask <= i_cfg_data;
        end
    end

    // Stage valid bits and ready chain: a stage loads when empty or when it
    // hands its item on in the same cycle.
    logic r_vld1, r_vld2, r_vld3, r_vld4;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4 = !r_vld4 || o_res.ready;
    assign rdy3 = !r_vld3 || rdy4;
    assign rdy2 = !r_vld2 || rdy3;
    assign rdy1 = !r_vld1 || rdy2;

    assign i_req.ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            if (rdy1) r_vld1 <= i_req.valid;
            if (rdy2) r_vld2 <= r_vld1;
            if (rdy3) r_vld3 <= r_vld2;
            if (rdy4) r_vld4 <= r_vld3;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: validate the request and compare the rate to the table.
    // above[r] set means the request is faster than table rate r, so
    // rate r lies below the ceiling rate.
    // ---------------------------------------------------------------
    logic                          n_s1_ok, n_s1_wide, n_s1_stereo;
    logic [afs_pkg::RATE_LEN-1:0]  n_s1_above;
    logic                          r_s1_ok, r_s1_wide, r_s1_stereo;
    logic [afs_pkg::RATE_LEN-1:0]  r_s1_above;

    always_comb begin
        n_s1_wide   = (i_req.data.desired_bits == afs_pkg::BITS_WIDE);
        n_s1_stereo = (i_req.data.desired_channels == afs_pkg::CHANS_STEREO);
        n_s1_ok     = (n_s1_stereo || i_req.data.desired_channels == afs_pkg::CHANS_MONO)
                   && (n_s1_wide || i_req.data.desired_bits == afs_pkg::BITS_NARROW);
        for (int r = 0; r < afs_pkg::RATE_LEN; r++) begin
            n_s1_above[r] = (r < RATE_CNT)
                && (i_req.data.desired_rate > $signed({15'd0, afs_pkg::RATE_TABLE[r]}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_ok     <= n_s1_ok;
            r_s1_wide   <= n_s1_wide;
            r_s1_stereo <= n_s1_stereo;
            r_s1_above  <= n_s1_above;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: split the usable mask at the ceiling rate, apply the size
    // and channel demands and pick the first nonempty candidate set.
    // ---------------------------------------------------------------
    logic [afs_pkg::MASK_W-1:0] slow_sel, usable, faster, slower;
    logic [afs_pkg::MASK_W-1:0] size_sel, chan_sel, fast_size, slow_size, fast_exact;
    logic [afs_pkg::MASK_W-1:0] n_s2_cand;
    afs_pkg::t_scan             n_s2_scan;
    logic [afs_pkg::MASK_W-1:0] r_s2_cand;
    afs_pkg::t_scan             r_s2_scan;

    always_comb begin
        for (int r = 0; r < afs_pkg::RATE_LEN; r++) begin
            slow_sel[4*r +: 4] = {4{r_s1_above[r]}};
        end
        usable     = r_supported_mask & USABLE;
        faster     = usable & ~slow_sel;
        slower     = usable & slow_sel;
        size_sel   = r_s1_wide   ? afs_pkg::WIDE_BITS   : '1;
        chan_sel   = r_s1_stereo ? afs_pkg::STEREO_BITS : '1;
        fast_size  = faster & size_sel;
        slow_size  = slower & size_sel;
        fast_exact = fast_size & chan_sel;

        n_s2_scan = afs_pkg::SCAN_LOW;
        if (!r_s1_ok) begin
            n_s2_cand = '0;
        end else if (|fast_exact) begin
            n_s2_cand = fast_exact;
        end else if (|fast_size) begin
            n_s2_cand = fast_size;
        end else if (|slow_size) begin
            n_s2_cand = slow_size;
            n_s2_scan = afs_pkg::SCAN_HIGH;
        end else if (|faster) begin
            n_s2_cand = faster;
        end else begin
            n_s2_cand = slower;
            n_s2_scan = afs_pkg::SCAN_HIGH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_s2_cand <= n_s2_cand;
            r_s2_scan <= n_s2_scan;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: priority encode, lowest or highest set bit.
    // ---------------------------------------------------------------
    logic [afs_pkg::IDX_W-1:0] n_s3_idx;
    logic                      n_s3_found;
    logic [afs_pkg::IDX_W-1:0] r_s3_idx;
    logic                      r_s3_found;

    always_comb begin
        n_s3_idx   = '0;
        n_s3_found = |r_s2_cand;
        for (int k = 0; k < afs_pkg::MASK_W; k++) begin
            if (r_s2_scan == afs_pkg::SCAN_HIGH) begin
                if (r_s2_cand[k]) n_s3_idx = afs_pkg::IDX_W'(k);
            end else begin
                if (r_s2_cand[afs_pkg::MASK_W-1-k]) begin
                    n_s3_idx = afs_pkg::IDX_W'(afs_pkg::MASK_W-1-k);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_s3_idx   <= n_s3_idx;
            r_s3_found <= n_s3_found;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: decode the bit position into a format; output register.
    // ---------------------------------------------------------------
    logic [afs_pkg::RIDX_W-1:0] rate_idx;
    afs_pkg::t_res              n_s4_res;
    afs_pkg::t_res              r_s4_res;

    always_comb begin
        rate_idx = r_s3_idx[afs_pkg::IDX_W-1:2];
        n_s4_res = '0;
        if (r_s3_found) begin
            n_s4_res.found           = 1'b1;
            n_s4_res.chosen_index    = r_s3_idx;
            n_s4_res.chosen_channels = r_s3_idx[0] ? afs_pkg::OUT_STEREO : afs_pkg::OUT_MONO;
            n_s4_res.chosen_bits     = r_s3_idx[1] ? afs_pkg::OUT_WIDE : afs_pkg::OUT_NARROW;
            n_s4_res.chosen_rate     = (rate_idx < afs_pkg::RIDX_W'(afs_pkg::RATE_LEN))
                ? afs_pkg::RATE_TABLE[rate_idx]
                : afs_pkg::RATE_TABLE[afs_pkg::RATE_LEN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_s4_res <= n_s4_res;
        end
    end

    assign o_res.valid = r_vld4;
    assign o_res.data  = r_s4_res;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_ready_when_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld4 |-> i_req.ready)
        else $error("input stalled with empty output stage");

    a_fail_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld4 && !r_s4_res.found) |->
        (r_s4_res.chosen_index == '0 && r_s4_res.chosen_channels == '0
         && r_s4_res.chosen_bits == '0 && r_s4_res.chosen_rate == '0))
        else $error("failed result carries nonzero fields");

    a_found_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld4 && r_s4_res.found) |->
        (r_s4_res.chosen_index < afs_pkg::IDX_W'(4 * RATE_CNT)
         && r_s4_res.chosen_rate != '0))
        else $error("chosen format outside the usable rates");

    a_decode_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld4 && r_s4_res.found) |->
        ((r_s4_res.chosen_bits == afs_pkg::OUT_WIDE) == r_s4_res.chosen_index[1]
         && (r_s4_res.chosen_channels == afs_pkg::OUT_STEREO) == r_s4_res.chosen_index[0]))
        else $error("format fields disagree with chosen index");

endmodule
